FILE: design/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg: shared constants and types for the accelerometer tilt unit
// Widths of the CORDIC vector and angle accumulator, the arctangent table
// in 2^-20 degree units and the output rounding and saturation limits.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int IN_W       = 16;   // raw accelerometer count
  localparam int ANG_W      = 16;   // output angle
  localparam int VEC_SHIFT  = 16;   // vector holds count * 2^16
  localparam int VEC_W      = 36;   // count * 2^16 * CORDIC gain * sqrt(2), plus sign
  localparam int ACC_FRAC   = 20;   // accumulator unit is 2^-20 degree
  localparam int ACC_W      = 31;   // +-180 start plus sum of table, plus sign
  localparam int TAB_LEN    = 24;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_BITS  = 7;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ACC_W:0]   rnd_t;

  localparam acc_t DEG180 = acc_t'(180) <<< ACC_FRAC;

  localparam acc_t ATAN_TAB [TAB_LEN] = '{
    acc_t'(47185920), acc_t'(27855475), acc_t'(14718068), acc_t'(7471121),
    acc_t'(3750058),  acc_t'(1876857),  acc_t'(938658),   acc_t'(469357),
    acc_t'(234682),   acc_t'(117342),   acc_t'(58671),    acc_t'(29335),
    acc_t'(14668),    acc_t'(7334),     acc_t'(3667),     acc_t'(1833),
    acc_t'(917),      acc_t'(458),      acc_t'(229),      acc_t'(115),
    acc_t'(57),       acc_t'(29),       acc_t'(14),       acc_t'(7)
  };

  // Output rounding: accumulator to ANGLE_FRAC_BITS fraction bits, ties up.
  localparam int   RND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam rnd_t RND_HALF = rnd_t'(1) <<< (RND_SH - 1);
  localparam int   ANG_LIM  = 180 << ANGLE_FRAC_BITS;
  localparam int   OUT_HI_I = (ANG_LIM > 32767) ? 32767 : ANG_LIM;
  localparam int   OUT_LO_I = (ANG_LIM > 32767) ? -32768 : -ANG_LIM;
  localparam rnd_t OUT_HI   = rnd_t'(OUT_HI_I);
  localparam rnd_t OUT_LO   = rnd_t'(OUT_LO_I);

endpackage

FILE: design/accel_pitch_roll_atan2_top.sv
// ----------------------------------------------------------------------------
// accel_pitch_roll_atan2_top: pitch and roll from one accelerometer sample
// Takes one sample every clock when not stalled, returns pitch = atan2(y, z)
// and roll = atan2(x, z) in 1/128 degree. One register stage prepares both
// vectors (half-turn for negative z), one stage per CORDIC iteration follows
// with both angles in parallel lanes, and a last stage clamps and rounds. A
// stall on the result side while a result is valid freezes the whole pipeline
// and is passed straight back to the sample side.
// ----------------------------------------------------------------------------
module accel_pitch_roll_atan2_top #(
  parameter int CORDIC_STEPS = apr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [apr_pkg::IN_W-1:0]   accel_x,
  input  logic signed [apr_pkg::IN_W-1:0]   accel_y,
  input  logic signed [apr_pkg::IN_W-1:0]   accel_z,
  output logic                              angle_valid,
  input  logic                              angle_stall,
  output logic signed [apr_pkg::ANG_W-1:0]  pitch_angle,
  output logic signed [apr_pkg::ANG_W-1:0]  roll_angle
);
  import apr_pkg::*;

  localparam int LANES = 2;   // lane 0: pitch (y over z), lane 1: roll (x over z)

  logic adv;
  assign adv          = !(angle_valid && angle_stall);
  assign sample_stall = !adv;

  // stage k holds the vector after k iterations
  logic valid [CORDIC_STEPS+1];
  vec_t vx    [CORDIC_STEPS+1][LANES];
  vec_t vy    [CORDIC_STEPS+1][LANES];
  acc_t acc   [CORDIC_STEPS+1][LANES];
  logic hold  [CORDIC_STEPS+1][LANES];   // zero numerator: angle already final

  // ---------------- prepare ----------------
  logic signed [IN_W-1:0] num      [LANES];
  logic signed [IN_W:0]   px       [LANES];
  logic signed [IN_W:0]   py       [LANES];
  vec_t                   vx_next  [LANES];
  vec_t                   vy_next  [LANES];
  acc_t                   acc_next [LANES];
  logic                   hold_next[LANES];

  assign num[0] = accel_y;
  assign num[1] = accel_x;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      px[l]        = (IN_W+1)'(accel_z);
      py[l]        = (IN_W+1)'(num[l]);
      acc_next[l]  = '0;
      hold_next[l] = (num[l] == '0);
      if (hold_next[l]) begin
        if (accel_z < 0) acc_next[l] = DEG180;
      end else if (accel_z < 0) begin
        // rotate by a half turn first
        px[l]       = -px[l];
        py[l]       = -py[l];
        acc_next[l] = (num[l] > 0) ? DEG180 : -DEG180;
      end
      vx_next[l] = vec_t'(px[l]) <<< VEC_SHIFT;
      vy_next[l] = vec_t'(py[l]) <<< VEC_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        vx[0][l]   <= vx_next[l];
        vy[0][l]   <= vy_next[l];
        acc[0][l]  <= acc_next[l];
        hold[0][l] <= hold_next[l];
      end
    end
  end

  // ---------------- CORDIC iterations ----------------
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    vec_t dx [LANES];
    vec_t dy [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        dx[l] = vy[k][l] >>> k;
        dy[l] = vx[k][l] >>> k;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (adv) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < LANES; l++) begin
          hold[k+1][l] <= hold[k][l];
          if (hold[k][l]) begin
            vx[k+1][l]  <= vx[k][l];
            vy[k+1][l]  <= vy[k][l];
            acc[k+1][l] <= acc[k][l];
          end else if (vy[k][l] > 0) begin
            vx[k+1][l]  <= vx[k][l] + dx[l];
            vy[k+1][l]  <= vy[k][l] - dy[l];
            acc[k+1][l] <= acc[k][l] + ATAN_TAB[k];
          end else begin
            vx[k+1][l]  <= vx[k][l] - dx[l];
            vy[k+1][l]  <= vy[k][l] + dy[l];
            acc[k+1][l] <= acc[k][l] - ATAN_TAB[k];
          end
        end
      end
    end
  end

  // ---------------- clamp, round, saturate ----------------
  acc_t cl    [LANES];
  rnd_t rsum  [LANES];
  rnd_t rq    [LANES];
  logic signed [ANG_W-1:0] ang [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cl[l] = acc[CORDIC_STEPS][l];
      if (cl[l] > DEG180)  cl[l] = DEG180;
      if (cl[l] < -DEG180) cl[l] = -DEG180;
      rsum[l] = rnd_t'(cl[l]) + RND_HALF;
      rq[l]   = rsum[l] >>> RND_SH;
      if (rq[l] > OUT_HI) begin
        ang[l] = OUT_HI[ANG_W-1:0];
      end else if (rq[l] < OUT_LO) begin
        ang[l] = OUT_LO[ANG_W-1:0];
      end else begin
        ang[l] = rq[l][ANG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (adv) begin
      angle_valid <= valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_angle <= ang[0];
      roll_angle  <= ang[1];
    end
  end

`ifndef SYNTH
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (rnd_t'(pitch_angle) <= OUT_HI) && (rnd_t'(pitch_angle) >= OUT_LO)
                 && (rnd_t'(roll_angle) <= OUT_HI) && (rnd_t'(roll_angle) >= OUT_LO))
    else $error("angle outside saturation range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    adv && valid[CORDIC_STEPS] |=> angle_valid)
    else $error("word lost at pipeline exit");

  a_hold_final: assert property (@(posedge clk) disable iff (rst)
    valid[CORDIC_STEPS] && hold[CORDIC_STEPS][0] |->
      (acc[CORDIC_STEPS][0] == '0) || (acc[CORDIC_STEPS][0] == DEG180))
    else $error("zero-numerator pitch angle disturbed by iterations");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(valid[CORDIC_STEPS]) && $stable(valid[0]))
    else $error("pipeline moved while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !angle_valid && !valid[0])
    else $error("valid not cleared by reset");
`endif

endmodule
